@@ hw/rtl/i2cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbb_pkg: shared types and constants of the bit-banged I2C master
// Operation codes, beat layouts, configuration struct and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbb_pkg;

	// Data bits moved per byte command
	localparam int unsigned BYTE_BITS = 8;

	// Operation codes of an input beat; the same code marks the active command
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] OP_WAIT  = 3'd5;
	localparam logic [2:0] CMD_IDLE = 3'd0;

	// Configuration register indexes
	localparam logic [1:0] REG_PHASE_DELAY   = 2'd0;
	localparam logic [1:0] REG_POLL_INTERVAL = 2'd1;
	localparam logic [1:0] REG_POLL_LIMIT    = 2'd2;

	// Configuration reset values
	localparam logic [15:0] PHASE_DELAY_RST   = 16'd50;
	localparam logic [19:0] POLL_INTERVAL_RST = 20'd1000;
	localparam logic [15:0] POLL_LIMIT_RST    = 16'd1000;

	typedef struct packed {
		logic [15:0] poll_limit;
		logic [19:0] poll_interval_ticks;
		logic [15:0] phase_delay_ticks;
	} cfg_t;

	// Input beat, last member in the lowest bits
	typedef struct packed {
		logic [1:0]           pad;
		logic                 scl_sense;
		logic                 sda_sample;
		logic                 send_ack;
		logic [BYTE_BITS-1:0] data_byte;
		logic [2:0]           op;
	} item_t;

	// Result beat, last member in the lowest bits
	typedef struct packed {
		logic                 rejected;
		logic                 timeout_error;
		logic                 ack_fail;
		logic [BYTE_BITS-1:0] read_byte;
		logic                 done_res;
		logic                 busy_res;
		logic                 sda_drive;
		logic                 sda_level;
		logic                 scl_level;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2c_bitbang_master.sv @@
// ----------------------------------------------------------------------------
// i2c_bitbang_master: bit-banged I2C master engine
// Each input beat is a tick or a command; each beat yields one result beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input beats (op, data_byte, send_ack and the sensed SDA/SCL
//   levels); a tick beat advances time, a command beat starts start, stop,
//   write byte, read byte or SCL stretch wait. m_* returns one result beat per
//   input beat: pin levels, busy/done, the last read byte and error flags.
//   cfg_* writes the phase delay, poll interval and poll limit registers; it
//   is always ready and should only be used while the engine is idle.
//   The result of a beat goes into the output register, or into the skid
//   register while the receiver stalls. One beat is taken every cycle while
//   s_tready is high; the engine state updates once per beat. A two-entry output
//   buffer (output register plus skid register) decouples m_tready from s_tready.
//   When the receiver stalls, one further beat is held in the skid register
//   and s_tready then drops until the receiver takes a beat.
//   Reset: engine idle, SCL and SDA latches high with SDA driven, read byte
//   and error flags zero, registers at 50 / 1000 / 1000, buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bitbang_master (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [2:0] op, [10:3] data_byte, [11] send_ack, [12] sda_sample,
	// [13] scl_sense, [15:14] zero
	input  wire  [15:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [12:5] read_byte, [13] ack_fail, [14] timeout_error, [15] rejected
	output logic [15:0] m_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [19:0] cfg_data
);

	i2cbb_pkg::cfg_t  cfg_q;
	i2cbb_pkg::item_t item;
	i2cbb_pkg::res_t  res;
	i2cbb_pkg::res_t  out_q, skid_q;
	logic             out_vld_q, skid_vld_q;
	logic             s_acc;

	assign item = s_tdata;
	assign s_tready = ~skid_vld_q;
	assign s_acc = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_delay_ticks <= i2cbb_pkg::PHASE_DELAY_RST;
			cfg_q.poll_interval_ticks <= i2cbb_pkg::POLL_INTERVAL_RST;
			cfg_q.poll_limit <= i2cbb_pkg::POLL_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				i2cbb_pkg::REG_PHASE_DELAY:   cfg_q.phase_delay_ticks <= cfg_data[15:0];
				i2cbb_pkg::REG_POLL_INTERVAL: cfg_q.poll_interval_ticks <= cfg_data;
				i2cbb_pkg::REG_POLL_LIMIT:    cfg_q.poll_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	i2cbb_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_acc (s_acc),
		.item     (item),
		.cfg      (cfg_q),
		.res      (res)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && m_tready) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= s_acc;
			end
		end else if (!out_vld_q) begin
			out_vld_q <= s_acc;
		end else if (s_acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((out_vld_q && m_tready) || !out_vld_q) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (s_acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/i2cbb_engine.sv @@
// ----------------------------------------------------------------------------
// i2cbb_engine: command state and pin sequencing
// Holds the command, phase, counters and pin latches; one beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_engine (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_acc,
	input  i2cbb_pkg::item_t  item,
	input  i2cbb_pkg::cfg_t   cfg,
	output i2cbb_pkg::res_t   res
);

	logic [2:0]  cmd_q, cmd_d;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [19:0] delay_q, delay_d;
	logic [15:0] poll_q, poll_d;
	logic        ack_q, ack_d;
	logic [1:0]  err_q, err_d;
	logic        scl_q, scl_d;
	logic        rel_q, rel_d;
	logic        sda_q, sda_d;
	logic        drv_q, drv_d;
	logic [7:0]  read_q, read_d;

	logic        done, rej, enter, fin;
	logic [2:0]  enter_ph;
	logic [19:0] hold_ticks, interval_ticks;
	logic [15:0] lim;

	// zero-valued registers act as one
	assign hold_ticks = (cfg.phase_delay_ticks == 16'd0) ? 20'd1
		: {4'd0, cfg.phase_delay_ticks};
	assign interval_ticks = (cfg.poll_interval_ticks == 20'd0) ? 20'd1
		: cfg.poll_interval_ticks;
	assign lim = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;

	// next state for the accepted beat
	always_comb begin
		cmd_d = cmd_q; phase_d = phase_q; bit_d = bit_q; shift_d = shift_q;
		delay_d = delay_q; poll_d = poll_q; ack_d = ack_q; err_d = err_q;
		scl_d = scl_q; rel_d = rel_q; sda_d = sda_q; drv_d = drv_q; read_d = read_q;
		done = 1'b0; rej = 1'b0; enter = 1'b0; fin = 1'b0; enter_ph = 3'd0;

		if (item_acc) begin
			if (item.op == i2cbb_pkg::OP_TICK) begin
				if (cmd_q != i2cbb_pkg::CMD_IDLE) begin
					delay_d = delay_q - 20'd1;
					if (delay_d == 20'd0) begin
						// phase over: act on its end
						case (cmd_q)
							i2cbb_pkg::OP_START, i2cbb_pkg::OP_STOP: begin
								if (phase_q >= 3'd3) fin = 1'b1;
								else begin
									enter = 1'b1;
									enter_ph = phase_q + 3'd1;
								end
							end
							i2cbb_pkg::OP_WRITE: begin
								if (phase_q == 3'd2) begin
									shift_d = {shift_q[6:0], 1'b0};
									bit_d = bit_q + 4'd1;
									enter = 1'b1;
									enter_ph = (bit_d < 4'(i2cbb_pkg::BYTE_BITS)) ? 3'd0 : 3'd3;
								end else if (phase_q == 3'd3) begin
									// acknowledge sample
									if (item.sda_sample) err_d[0] = 1'b1;
									scl_d = 1'b0;
									drv_d = 1'b1;
									enter = 1'b1;
									enter_ph = 3'd4;
								end else if (phase_q >= 3'd4) begin
									fin = 1'b1;
								end else begin
									enter = 1'b1;
									enter_ph = phase_q + 3'd1;
								end
							end
							i2cbb_pkg::OP_READ: begin
								if (phase_q == 3'd0) begin
									shift_d = shift_q | {7'd0, item.sda_sample};
									enter = 1'b1;
									enter_ph = 3'd1;
								end else if (phase_q == 3'd2) begin
									bit_d = bit_q + 4'd1;
									enter = 1'b1;
									enter_ph = (bit_d < 4'(i2cbb_pkg::BYTE_BITS)) ? 3'd0 : 3'd3;
								end else if (phase_q >= 3'd5) begin
									scl_d = 1'b0;
									read_d = shift_q;
									fin = 1'b1;
								end else begin
									enter = 1'b1;
									enter_ph = phase_q + 3'd1;
								end
							end
							i2cbb_pkg::OP_WAIT: begin
								if (item.scl_sense) begin
									rel_d = 1'b0;
									fin = 1'b1;
								end else begin
									poll_d = poll_q + 16'd1;
									if (poll_d >= lim) begin
										err_d[1] = 1'b1;
										rel_d = 1'b0;
										fin = 1'b1;
									end else begin
										delay_d = interval_ticks;
									end
								end
							end
							default: fin = 1'b1;
						endcase
						if (fin) begin
							cmd_d = i2cbb_pkg::CMD_IDLE;
							phase_d = 3'd0;
							done = 1'b1;
						end
					end
				end
			end else if (item.op <= i2cbb_pkg::OP_WAIT) begin
				if (cmd_q != i2cbb_pkg::CMD_IDLE) begin
					rej = 1'b1;
				end else begin
					// new command
					cmd_d = item.op;
					err_d = 2'd0;
					bit_d = 4'd0;
					poll_d = 16'd0;
					if (item.op == i2cbb_pkg::OP_WRITE) begin
						shift_d = item.data_byte;
					end else if (item.op == i2cbb_pkg::OP_READ) begin
						ack_d = item.send_ack;
						shift_d = 8'd0;
						drv_d = 1'b0;
						sda_d = 1'b1;
					end
					enter = 1'b1;
					enter_ph = 3'd0;
				end
			end
		end

		// pin action of the phase being entered
		if (enter) begin
			phase_d = enter_ph;
			delay_d = hold_ticks;
			case (cmd_d)
				i2cbb_pkg::OP_START: begin
					if (enter_ph == 3'd0) begin sda_d = 1'b1; drv_d = 1'b1; end
					else if (enter_ph == 3'd1) scl_d = 1'b1;
					else if (enter_ph == 3'd2) sda_d = 1'b0;
					else scl_d = 1'b0;
				end
				i2cbb_pkg::OP_STOP: begin
					if (enter_ph == 3'd0) begin sda_d = 1'b0; drv_d = 1'b1; end
					else if (enter_ph == 3'd1) scl_d = 1'b1;
					else if (enter_ph == 3'd2) sda_d = 1'b1;
					else scl_d = 1'b0;
				end
				i2cbb_pkg::OP_WRITE: begin
					if (enter_ph == 3'd0) begin sda_d = shift_d[7]; drv_d = 1'b1; end
					else if (enter_ph == 3'd1) scl_d = 1'b1;
					else if (enter_ph == 3'd2) scl_d = 1'b0;
					else if (enter_ph == 3'd3) begin drv_d = 1'b0; scl_d = 1'b1; end
				end
				i2cbb_pkg::OP_READ: begin
					if (enter_ph == 3'd0) begin
						scl_d = 1'b1;
						shift_d = {shift_d[6:0], 1'b0};
					end
					else if (enter_ph == 3'd2) scl_d = 1'b0;
					else if (enter_ph == 3'd3) drv_d = 1'b1;
					else if (enter_ph == 3'd4) sda_d = ~ack_d;
					else if (enter_ph == 3'd5) scl_d = 1'b1;
				end
				i2cbb_pkg::OP_WAIT: begin
					rel_d = 1'b1;
					delay_d = interval_ticks;
				end
				default: ;
			endcase
		end
	end

	// result fields follow the updated state
	always_comb begin
		res.scl_level     = rel_d | scl_d;
		res.sda_level     = sda_d;
		res.sda_drive     = drv_d;
		res.busy_res      = (cmd_d != i2cbb_pkg::CMD_IDLE);
		res.done_res      = done;
		res.read_byte     = read_d;
		res.ack_fail      = err_d[0];
		res.timeout_error = err_d[1];
		res.rejected      = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= i2cbb_pkg::CMD_IDLE;
			phase_q <= 3'd0;
			bit_q <= 4'd0;
			shift_q <= 8'd0;
			delay_q <= 20'd0;
			poll_q <= 16'd0;
			ack_q <= 1'b0;
			err_q <= 2'd0;
			scl_q <= 1'b1;
			rel_q <= 1'b0;
			sda_q <= 1'b1;
			drv_q <= 1'b1;
			read_q <= 8'd0;
		end else begin
			cmd_q <= cmd_d;
			phase_q <= phase_d;
			bit_q <= bit_d;
			shift_q <= shift_d;
			delay_q <= delay_d;
			poll_q <= poll_d;
			ack_q <= ack_d;
			err_q <= err_d;
			scl_q <= scl_d;
			rel_q <= rel_d;
			sda_q <= sda_d;
			drv_q <= drv_d;
			read_q <= read_d;
		end
	end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the bit-banged I2C master engine
// Drives tick and command beats with random gaps and sensed bus levels.
// An engine model in the scoreboard predicts each result beat, which is
// then compared field by field. Registers are changed between idle phases.
// ----------------------------------------------------------------------------

// Engine model plus the queue of result beats still owed by the block
class i2c_scoreboard;
	i2cbb_pkg::cfg_t regs;
	logic [2:0]  active_cmd;
	logic [4:0]  phase;
	logic [3:0]  bit_idx;
	logic [7:0]  shifter;
	logic [19:0] delay_left;
	logic [15:0] polls;
	logic        ack_level;
	logic [1:0]  err_flags;
	logic        scl_latch;
	logic        scl_release;
	logic        sda_latch;
	logic        sda_oe;
	logic [7:0]  last_read;
	i2cbb_pkg::res_t owed_results[$];
	int unsigned mismatches;

	function new();
		regs.phase_delay_ticks   = i2cbb_pkg::PHASE_DELAY_RST;
		regs.poll_interval_ticks = i2cbb_pkg::POLL_INTERVAL_RST;
		regs.poll_limit          = i2cbb_pkg::POLL_LIMIT_RST;
		active_cmd  = i2cbb_pkg::CMD_IDLE;
		phase       = '0;
		bit_idx     = '0;
		shifter     = '0;
		delay_left  = '0;
		polls       = '0;
		ack_level   = 1'b0;
		err_flags   = '0;
		scl_latch   = 1'b1;
		scl_release = 1'b0;
		sda_latch   = 1'b1;
		sda_oe      = 1'b1;
		last_read   = '0;
		mismatches  = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [19:0] val);
		case (idx)
			i2cbb_pkg::REG_PHASE_DELAY:   regs.phase_delay_ticks = val[15:0];
			i2cbb_pkg::REG_POLL_INTERVAL: regs.poll_interval_ticks = val;
			i2cbb_pkg::REG_POLL_LIMIT:    regs.poll_limit = val[15:0];
			default: ;
		endcase
	endfunction

	function bit busy();
		return active_cmd != i2cbb_pkg::CMD_IDLE;
	endfunction

	function int unsigned outstanding();
		return owed_results.size();
	endfunction

	// zero in a register acts as one
	function logic [19:0] hold_len();
		return (regs.phase_delay_ticks == 0) ? 20'd1 : {4'd0, regs.phase_delay_ticks};
	endfunction

	function logic [19:0] poll_len();
		return (regs.poll_interval_ticks == 0) ? 20'd1 : regs.poll_interval_ticks;
	endfunction

	// Enter a phase: its pin action takes effect at once
	function void open_phase(logic [4:0] ph);
		phase = ph;
		delay_left = hold_len();
		case (active_cmd)
			i2cbb_pkg::OP_START: begin
				if (phase == 0) begin
					sda_latch = 1'b1;
					sda_oe = 1'b1;
				end else if (phase == 1) scl_latch = 1'b1;
				else if (phase == 2) sda_latch = 1'b0;
				else scl_latch = 1'b0;
			end
			i2cbb_pkg::OP_STOP: begin
				if (phase == 0) begin
					sda_latch = 1'b0;
					sda_oe = 1'b1;
				end else if (phase == 1) scl_latch = 1'b1;
				else if (phase == 2) sda_latch = 1'b1;
				else scl_latch = 1'b0;
			end
			i2cbb_pkg::OP_WRITE: begin
				if (phase == 0) begin
					sda_latch = shifter[7];
					sda_oe = 1'b1;
				end else if (phase == 1) scl_latch = 1'b1;
				else if (phase == 2) scl_latch = 1'b0;
				else if (phase == 3) begin
					sda_oe = 1'b0;
					scl_latch = 1'b1;
				end
			end
			i2cbb_pkg::OP_READ: begin
				if (phase == 0) begin
					scl_latch = 1'b1;
					shifter = shifter << 1;
				end else if (phase == 2) scl_latch = 1'b0;
				else if (phase == 3) sda_oe = 1'b1;
				else if (phase == 4) sda_latch = ~ack_level;
				else if (phase == 5) scl_latch = 1'b1;
			end
			i2cbb_pkg::OP_WAIT: begin
				scl_release = 1'b1;
				delay_left = poll_len();
			end
			default: ;
		endcase
	endfunction

	// Current phase has run out; returns 1 when the command is complete
	function bit close_phase(logic sda_in, logic scl_in);
		logic [15:0] lim;
		case (active_cmd)
			i2cbb_pkg::OP_START, i2cbb_pkg::OP_STOP: begin
				if (phase >= 3) return 1'b1;
				open_phase(phase + 5'd1);
				return 1'b0;
			end
			i2cbb_pkg::OP_WRITE: begin
				if (phase == 2) begin
					shifter = shifter << 1;
					bit_idx = bit_idx + 4'd1;
					open_phase(bit_idx < i2cbb_pkg::BYTE_BITS ? 5'd0 : 5'd3);
					return 1'b0;
				end
				// acknowledge slot
				if (phase == 3) begin
					if (sda_in) err_flags[0] = 1'b1;
					scl_latch = 1'b0;
					sda_oe = 1'b1;
					open_phase(5'd4);
					return 1'b0;
				end
				if (phase >= 4) return 1'b1;
				open_phase(phase + 5'd1);
				return 1'b0;
			end
			i2cbb_pkg::OP_READ: begin
				if (phase == 0) begin
					shifter[0] = shifter[0] | sda_in;
					open_phase(5'd1);
					return 1'b0;
				end
				if (phase == 2) begin
					bit_idx = bit_idx + 4'd1;
					open_phase(bit_idx < i2cbb_pkg::BYTE_BITS ? 5'd0 : 5'd3);
					return 1'b0;
				end
				if (phase >= 5) begin
					scl_latch = 1'b0;
					last_read = shifter;
					return 1'b1;
				end
				open_phase(phase + 5'd1);
				return 1'b0;
			end
			i2cbb_pkg::OP_WAIT: begin
				// stretch released early
				if (scl_in) begin
					scl_release = 1'b0;
					return 1'b1;
				end
				polls = polls + 16'd1;
				lim = (regs.poll_limit == 0) ? 16'd1 : regs.poll_limit;
				if (polls >= lim) begin
					err_flags[1] = 1'b1;
					scl_release = 1'b0;
					return 1'b1;
				end
				delay_left = poll_len();
				return 1'b0;
			end
			default: return 1'b1;
		endcase
	endfunction

	// Accepted input beat: advance the model and queue its result beat
	function void take_beat(i2cbb_pkg::item_t it);
		i2cbb_pkg::res_t r;
		bit fin;
		bit rej;
		fin = 1'b0;
		rej = 1'b0;
		if (it.op == i2cbb_pkg::OP_TICK) begin
			if (busy()) begin
				delay_left = delay_left - 20'd1;
				if (delay_left == 0) begin
					if (close_phase(it.sda_sample, it.scl_sense)) begin
						active_cmd = i2cbb_pkg::CMD_IDLE;
						phase = '0;
						fin = 1'b1;
					end
				end
			end
		end else if (it.op <= i2cbb_pkg::OP_WAIT) begin
			if (busy()) rej = 1'b1;
			else begin
				active_cmd = it.op;
				err_flags = '0;
				bit_idx = '0;
				polls = '0;
				if (it.op == i2cbb_pkg::OP_WRITE) shifter = it.data_byte;
				else if (it.op == i2cbb_pkg::OP_READ) begin
					ack_level = it.send_ack;
					shifter = '0;
					sda_oe = 1'b0;
					sda_latch = 1'b1;
				end
				open_phase(5'd0);
			end
		end
		r.scl_level     = scl_release | scl_latch;
		r.sda_level     = sda_latch;
		r.sda_drive     = sda_oe;
		r.busy_res      = busy();
		r.done_res      = fin;
		r.read_byte     = last_read;
		r.ack_fail      = err_flags[0];
		r.timeout_error = err_flags[1];
		r.rejected      = rej;
		owed_results.push_back(r);
	endfunction

	function void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Result beat from the block: compare with the oldest prediction
	function void check_beat(i2cbb_pkg::res_t got);
		i2cbb_pkg::res_t want;
		if (owed_results.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
			mismatches++;
			return;
		end
		want = owed_results.pop_front();
		check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
		check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
		check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
		check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
		check_field("done_res", 8'(want.done_res), 8'(got.done_res));
		check_field("read_byte", want.read_byte, got.read_byte);
		check_field("ack_fail", 8'(want.ack_fail), 8'(got.ack_fail));
		check_field("timeout_error", 8'(want.timeout_error), 8'(got.timeout_error));
		check_field("rejected", 8'(want.rejected), 8'(got.rejected));
	endfunction
endclass

module testbench;

	// op codes the engine does not define
	localparam logic [2:0] OP_UNDEF_A = 3'd6;
	localparam logic [2:0] OP_UNDEF_B = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	int unsigned send_gap_max = 0;
	int unsigned recv_stall_max = 0;
	int unsigned recv_hold = 0;

	i2c_scoreboard sb = new();

	i2c_bitbang_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	function automatic i2cbb_pkg::item_t make_beat(logic [2:0] op, logic [7:0] data,
			logic ack, logic sda, logic scl);
		i2cbb_pkg::item_t it;
		it.pad        = '0;
		it.op         = op;
		it.data_byte  = data;
		it.send_ack   = ack;
		it.sda_sample = sda;
		it.scl_sense  = scl;
		return it;
	endfunction

	// Offer one input beat after a random gap; model it once it is taken
	task automatic send_beat(i2cbb_pkg::item_t it);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= it;
		do @(posedge clk); while (!s_tready);
		sb.take_beat(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Command with fixed sensed levels, ticked until it completes
	task automatic run_command(logic [2:0] op, logic [7:0] data, logic ack, logic sda,
			logic scl);
		send_beat(make_beat(op, data, ack, sda, scl));
		while (sb.busy())
			send_beat(make_beat(i2cbb_pkg::OP_TICK, ~data, ack, sda, scl));
	endtask

	// Tick the engine to idle, stop offering and let every owed result arrive
	task automatic settle();
		while (sb.busy())
			send_beat(make_beat(i2cbb_pkg::OP_TICK, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1))));
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Mostly complete commands with random content, some stray beats mixed in
	task automatic random_traffic(int unsigned budget);
		int unsigned left;
		int unsigned scl_odds;
		logic [2:0] op;
		left = budget;
		while (left > 0) begin
			if ($urandom_range(0, 7) == 0) begin
				send_gap_max = $urandom_range(0, 1) ? 19 : 0;
				recv_stall_max = $urandom_range(0, 1) ? 19 : 0;
			end
			if ($urandom_range(0, 6) == 0) begin
				// idle tick or undefined op
				op = $urandom_range(0, 1) ? i2cbb_pkg::OP_TICK
					: 3'($urandom_range(OP_UNDEF_A, OP_UNDEF_B));
				send_beat(make_beat(op, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
			end else begin
				op = 3'($urandom_range(i2cbb_pkg::OP_START, i2cbb_pkg::OP_WAIT));
				scl_odds = $urandom_range(1, 4);
				send_beat(make_beat(op, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
				left--;
				while (sb.busy() && left > 0) begin
					if ($urandom_range(0, 15) == 0) begin
						// command or undefined op while busy
						send_beat(make_beat(3'($urandom_range(i2cbb_pkg::OP_START, OP_UNDEF_B)),
							8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					end else begin
						send_beat(make_beat(i2cbb_pkg::OP_TICK, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							$urandom_range(1, scl_odds) == 1));
						left--;
					end
				end
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin : receiver
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			if (recv_hold > 0) begin
				repeat (recv_hold) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				recv_hold = 0;
			end
			stall = $urandom_range(0, recv_stall_max);
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_beat(i2cbb_pkg::res_t'(m_tdata));
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fastest timing, short poll limit
		write_reg(i2cbb_pkg::REG_PHASE_DELAY, 20'd1);
		write_reg(i2cbb_pkg::REG_POLL_INTERVAL, 20'd1);
		write_reg(i2cbb_pkg::REG_POLL_LIMIT, 20'd2);
		send_beat(make_beat(i2cbb_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(make_beat(OP_UNDEF_A, 8'hAA, 1'b1, 1'b1, 1'b1));
		send_beat(make_beat(OP_UNDEF_B, 8'h55, 1'b0, 1'b0, 1'b1));
		// start, with a write arriving while it runs
		send_beat(make_beat(i2cbb_pkg::OP_START, 8'h00, 1'b0, 1'b1, 1'b1));
		send_beat(make_beat(i2cbb_pkg::OP_WRITE, 8'h3C, 1'b1, 1'b0, 1'b0));
		run_command(i2cbb_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
		run_command(i2cbb_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1);
		run_command(i2cbb_pkg::OP_WRITE, 8'h00, 1'b1, 1'b0, 1'b0);
		run_command(i2cbb_pkg::OP_READ, 8'h00, 1'b1, 1'b1, 1'b1);
		run_command(i2cbb_pkg::OP_READ, 8'hFF, 1'b0, 1'b0, 1'b0);
		run_command(i2cbb_pkg::OP_WAIT, 8'h00, 1'b0, 1'b0, 1'b1);
		run_command(i2cbb_pkg::OP_WAIT, 8'h00, 1'b0, 1'b1, 1'b0);
		run_command(i2cbb_pkg::OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
		settle();

		// zero registers act as one
		write_reg(i2cbb_pkg::REG_PHASE_DELAY, 20'd0);
		write_reg(i2cbb_pkg::REG_POLL_INTERVAL, 20'd0);
		write_reg(i2cbb_pkg::REG_POLL_LIMIT, 20'd0);
		send_gap_max = 19;
		recv_stall_max = 19;
		random_traffic(350);
		settle();

		// long receiver hold-off so the block backs up
		write_reg(i2cbb_pkg::REG_PHASE_DELAY, 20'd2);
		write_reg(i2cbb_pkg::REG_POLL_INTERVAL, 20'd3);
		write_reg(i2cbb_pkg::REG_POLL_LIMIT, 20'd5);
		send_gap_max = 0;
		recv_hold = 300;
		random_traffic(450);
		settle();

		// largest poll limit
		write_reg(i2cbb_pkg::REG_PHASE_DELAY, 20'd1);
		write_reg(i2cbb_pkg::REG_POLL_INTERVAL, 20'd1);
		write_reg(i2cbb_pkg::REG_POLL_LIMIT, 20'd65535);
		random_traffic(350);
		settle();

		// single poll, no idling to begin with
		write_reg(i2cbb_pkg::REG_PHASE_DELAY, 20'd3);
		write_reg(i2cbb_pkg::REG_POLL_INTERVAL, 20'd2);
		write_reg(i2cbb_pkg::REG_POLL_LIMIT, 20'd1);
		send_gap_max = 0;
		recv_stall_max = 0;
		random_traffic(450);
		settle();

		// all registers at their maximum; the engine is left mid-command
		write_reg(i2cbb_pkg::REG_PHASE_DELAY, 20'd65535);
		write_reg(i2cbb_pkg::REG_POLL_INTERVAL, 20'hFFFFF);
		write_reg(i2cbb_pkg::REG_POLL_LIMIT, 20'd65535);
		random_traffic(100);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/i2cbb_pkg.sv
hw/rtl/i2cbb_engine.sv
hw/rtl/i2c_bitbang_master.sv
test/testbench.sv
